### src/wtsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtsd_pkg: shared definitions of the temperature stability detector
// Field widths, register indexes, reset values and the structs that pass
// between the ring, the statistics pipeline and the top level.
// ----------------------------------------------------------------------------
package wtsd_pkg;

  localparam int TEMP_W     = 16;
  localparam int THR_W      = 10;
  localparam int DWELL_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int WINDOW_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 2'd2;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST  = 16'sd9300;
  localparam logic [THR_W-1:0]         THRESHOLD_RST = 10'd30;
  localparam logic [DWELL_W-1:0]       DWELL_RST     = 12'd5;
  localparam logic [DWELL_W-1:0]       DWELL_MAX     = 12'd3600;

  typedef struct packed {
    logic push;
    logic clear;
  } wtsd_ring_ctl_t;

  typedef struct packed {
    logic                     cmd;
    logic                     full;
    logic                     near;
    logic                     low;
    logic signed [TEMP_W-1:0] mean;
  } wtsd_meas_t;

endpackage
`default_nettype wire

### src/wtsd_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtsd_ring: reading history
// Ring memory of WINDOW readings with write index and fill count. The entry
// that the next item will overwrite is read ahead into a register, so the
// registered read data is ready when that item arrives.
// ----------------------------------------------------------------------------
module wtsd_ring #(
  parameter int WINDOW = wtsd_pkg::WINDOW_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire wtsd_pkg::wtsd_ring_ctl_t       ctl,
  input  wire logic signed [wtsd_pkg::TEMP_W-1:0] wdata,
  output logic signed [wtsd_pkg::TEMP_W-1:0]  old_o,
  output logic                                full_o
);
  import wtsd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(WINDOW - 1);

  logic signed [TEMP_W-1:0] mem [WINDOW];
  logic signed [TEMP_W-1:0] rd_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;

  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    if (ctl.clear) begin
      idx_nxt  = '0;
      fill_nxt = '0;
    end else if (ctl.push) begin
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
      if (fill_r != FILL_MAX) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
    end
  end

  // The read address never equals the write address in the same cycle.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[idx_r] <= wdata;
    end
    rd_r <= mem[idx_nxt];
  end

  // Slots not yet written since the last clear count as zero.
  assign old_o  = (fill_r == FILL_MAX) ? rd_r : '0;
  assign full_o = (fill_r == FILL_MAX) || (fill_r == FILL_LAST);

endmodule
`default_nettype wire

### src/wtsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtsd_datapath: window statistics pipeline
// Seven registered stages: input, squares, running sums, products, variance
// and offset, threshold tests, and the window mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module wtsd_datapath #(
  parameter int WINDOW = wtsd_pkg::WINDOW_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire logic signed [wtsd_pkg::TEMP_W-1:0] setpoint,
  input  wire logic [wtsd_pkg::THR_W-1:0]         threshold,
  input  wire                                     i_valid,
  output logic                                    i_ready,
  input  wire                                     i_cmd,
  input  wire logic signed [wtsd_pkg::TEMP_W-1:0] i_temp,
  input  wire logic signed [wtsd_pkg::TEMP_W-1:0] i_old,
  input  wire                                     i_full,
  output logic                                    o_valid,
  input  wire                                     o_ready,
  output wtsd_pkg::wtsd_meas_t                    o_meas
);
  import wtsd_pkg::*;

  localparam int NSTG = 7;
  localparam int LW   = $clog2(WINDOW);
  localparam int SW   = TEMP_W + LW;        // running sum, signed
  localparam int QW   = 2 * TEMP_W + LW;    // running square sum, signed
  localparam int VW   = 2 * SW;             // scaled variance, signed
  localparam int DW   = TEMP_W + 1 + LW;    // mean offset, signed
  localparam int AW   = TEMP_W + LW;        // offset sum, unsigned
  localparam int RW   = TEMP_W + 1;         // reciprocal and quotient
  localparam int RECIP_I = (1 << AW) / WINDOW;
  localparam logic [RW-1:0]        RECIP  = RW'(RECIP_I);
  localparam logic signed [SW:0]   OFFSET = (SW + 1)'(WINDOW * 32768);
  localparam logic [TEMP_W-1:0]    SIGN_FLIP = 16'h8000;

  // Handshake of the stage chain.
  logic [NSTG:1]   v_r, v_in, ld;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = o_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_in[1] = i_valid;
    for (int k = 2; k <= NSTG; k++) begin
      v_in[k] = v_r[k-1];
    end
    ld = rdy[NSTG:1] & v_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign i_ready = rdy[1];
  assign o_valid = v_r[NSTG];

  // Limits derived from the registers; settled long before an item needs them.
  logic signed [DW-1:0] wsp_r, wth_r;
  logic [2*THR_W-1:0]   thsq_r;
  logic signed [VW-1:0] thr_sq_r;

  always_ff @(posedge clk) begin
    wsp_r    <= DW'(setpoint) * DW'(WINDOW);
    wth_r    <= DW'(threshold) * DW'(WINDOW);
    thsq_r   <= (2 * THR_W)'(threshold) * (2 * THR_W)'(threshold);
    thr_sq_r <= VW'(thsq_r) * VW'(WINDOW * WINDOW);
  end

  // Stage payloads.
  logic [NSTG:1]            cmd_r, full_r;
  logic signed [TEMP_W-1:0] p1_t, p1_old;
  logic signed [2*TEMP_W-1:0] p2_tt, p2_oo;
  logic signed [TEMP_W:0]   p2_dlt;
  logic signed [SW-1:0]     sum_r;
  logic signed [QW-1:0]     sq_r;
  logic signed [VW-1:0]     p4_ss, p4_wq, p5_var;
  logic signed [DW-1:0]     p4_d, p5_ad;
  logic signed [SW:0]       offs_sum;
  logic [AW-1:0]            p4_a, p5_a, p6_r;
  logic [AW+RW-1:0]         quot_prod;
  logic [RW-1:0]            p5_q0, p6_q0, q_fix;
  logic                     p6_near, p6_low, p7_near, p7_low;
  logic signed [TEMP_W-1:0] p7_mean;

  assign offs_sum  = (SW + 1)'(sum_r) + OFFSET;
  assign quot_prod = (AW + RW)'(p4_a) * (AW + RW)'(RECIP);
  assign q_fix     = (p6_r >= AW'(WINDOW)) ? p6_q0 + RW'(1) : p6_q0;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cmd_r[1]  <= i_cmd;
      full_r[1] <= i_full;
      p1_t      <= i_temp;
      p1_old    <= i_old;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (ld[k]) begin
        cmd_r[k]  <= cmd_r[k-1];
        full_r[k] <= full_r[k-1];
      end
    end
    if (ld[2]) begin
      p2_tt  <= (2 * TEMP_W)'(p1_t) * (2 * TEMP_W)'(p1_t);
      p2_oo  <= (2 * TEMP_W)'(p1_old) * (2 * TEMP_W)'(p1_old);
      p2_dlt <= (TEMP_W + 1)'(p1_t) - (TEMP_W + 1)'(p1_old);
    end
    if (ld[4]) begin
      p4_ss <= VW'(sum_r) * VW'(sum_r);
      p4_wq <= VW'(sq_r) * VW'(WINDOW);
      p4_d  <= DW'(sum_r) - wsp_r;
      p4_a  <= AW'(offs_sum);
    end
    if (ld[5]) begin
      p5_var <= p4_wq - p4_ss;
      p5_ad  <= (p4_d < 0) ? -p4_d : p4_d;
      p5_q0  <= quot_prod[AW+RW-1:AW];
      p5_a   <= p4_a;
    end
    if (ld[6]) begin
      p6_low  <= p5_var < thr_sq_r;
      p6_near <= p5_ad < wth_r;
      p6_r    <= p5_a - AW'(p5_q0) * AW'(WINDOW);
      p6_q0   <= p5_q0;
    end
    if (ld[7]) begin
      p7_near <= p6_near;
      p7_low  <= p6_low;
      // The quotient is of the sum plus WINDOW*32768, so flipping the sign
      // bit takes the offset back off.
      p7_mean <= signed'(q_fix[TEMP_W-1:0] ^ SIGN_FLIP);
    end
  end

  // The running sums are the payload of stage three: they change only when
  // the next item enters that stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
    end else if (ld[3]) begin
      if (cmd_r[2]) begin
        sum_r <= '0;
        sq_r  <= '0;
      end else begin
        sum_r <= sum_r + SW'(p2_dlt);
        sq_r  <= sq_r + QW'(p2_tt) - QW'(p2_oo);
      end
    end
  end

  assign o_meas.cmd  = cmd_r[NSTG];
  assign o_meas.full = full_r[NSTG];
  assign o_meas.near = p7_near;
  assign o_meas.low  = p7_low;
  assign o_meas.mean = p7_mean;

endmodule
`default_nettype wire

### src/windowed_temperature_stability_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_temperature_stability_detector_top: temperature stability detector
// Moving window mean and spread over WINDOW one-second readings, with a
// dwell timer that declares and latches a stable temperature.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low; the rate
// is set by the running sums and the dwell counter, each updated once per
// item, and by the one write and one look-ahead read per cycle of the
// reading memory. The history memory holds WINDOW words and needs no
// clearing pass after reset or a clear command: a fill count makes slots
// not yet written read as zero. Registers may be written only while no
// item is in flight.
module windowed_temperature_stability_detector_top #(
  parameter int WINDOW = wtsd_pkg::WINDOW_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_we,
  input  wire logic [wtsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wtsd_pkg::TEMP_W-1:0]           cfg_wdata,
  input  wire                                        in_valid,
  output logic                                       in_stall,
  input  wire                                        in_command,
  input  wire logic signed [wtsd_pkg::TEMP_W-1:0]    in_temperature,
  output logic                                       out_valid,
  input  wire                                        out_stall,
  output logic                                       out_stable,
  output logic signed [wtsd_pkg::TEMP_W-1:0]         out_stable_temperature,
  output logic signed [wtsd_pkg::TEMP_W-1:0]         out_window_mean,
  output logic                                       out_window_full,
  output logic                                       out_near_setpoint,
  output logic                                       out_low_spread
);
  import wtsd_pkg::*;

  // Configuration registers.
  logic signed [TEMP_W-1:0] setpoint_r;
  logic [THR_W-1:0]         threshold_r;
  logic [DWELL_W-1:0]       dwell_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= SETPOINT_RST;
      threshold_r <= THRESHOLD_RST;
      dwell_cfg_r <= DWELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETPOINT:  setpoint_r  <= signed'(cfg_wdata);
        CFG_THRESHOLD: threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_DWELL:     dwell_cfg_r <= cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side.
  logic                     dp_ready, accept;
  wtsd_ring_ctl_t           ring_ctl;
  logic signed [TEMP_W-1:0] ring_old;
  logic                     ring_full;

  assign accept         = in_valid && dp_ready;
  assign in_stall       = !dp_ready;
  assign ring_ctl.push  = accept && !in_command;
  assign ring_ctl.clear = accept && in_command;

  wtsd_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .wdata  (in_temperature),
    .old_o  (ring_old),
    .full_o (ring_full)
  );

  logic       m_valid, out_rdy, m_take;
  wtsd_meas_t meas;

  wtsd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .setpoint  (setpoint_r),
    .threshold (threshold_r),
    .i_valid   (in_valid),
    .i_ready   (dp_ready),
    .i_cmd     (in_command),
    .i_temp    (in_temperature),
    .i_old     (ring_old),
    .i_full    (ring_full),
    .o_valid   (m_valid),
    .o_ready   (out_rdy),
    .o_meas    (meas)
  );

  // Dwell tracking, updated as each item enters the output register.
  logic                     valid_r;
  logic                     cand_r, cand_nxt;
  logic                     stable_r, stable_nxt;
  logic [DWELL_W-1:0]       dwell_r, dwell_nxt;
  logic signed [TEMP_W-1:0] latched_r, latched_nxt;
  logic signed [TEMP_W-1:0] mean_r;
  logic                     full_r, near_r, low_r;

  assign out_rdy = !valid_r || !out_stall;
  assign m_take  = m_valid && out_rdy;

  always_comb begin
    cand_nxt    = cand_r;
    stable_nxt  = stable_r;
    dwell_nxt   = dwell_r;
    latched_nxt = latched_r;
    if (m_take) begin
      if (meas.cmd) begin
        cand_nxt   = 1'b0;
        stable_nxt = 1'b0;
        dwell_nxt  = '0;
      end else if (meas.full) begin
        if (meas.near && meas.low) begin
          if (!cand_r) begin
            cand_nxt  = 1'b1;
            dwell_nxt = '0;
          end else if (dwell_r < DWELL_MAX) begin
            dwell_nxt = dwell_r + DWELL_W'(1);
          end
          if (dwell_nxt >= dwell_cfg_r && !stable_r) begin
            stable_nxt  = 1'b1;
            latched_nxt = meas.mean;
          end
        end else begin
          cand_nxt   = 1'b0;
          stable_nxt = 1'b0;
          dwell_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      cand_r    <= 1'b0;
      stable_r  <= 1'b0;
      dwell_r   <= '0;
      latched_r <= '0;
    end else begin
      if (out_rdy) begin
        valid_r <= m_valid;
      end
      cand_r    <= cand_nxt;
      stable_r  <= stable_nxt;
      dwell_r   <= dwell_nxt;
      latched_r <= latched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (m_take) begin
      mean_r <= meas.cmd ? '0 : meas.mean;
      full_r <= !meas.cmd && meas.full;
      near_r <= !meas.cmd && meas.full && meas.near;
      low_r  <= !meas.cmd && meas.full && meas.low;
    end
  end

  // The stable state changes only when a new item enters the output
  // register, so it serves as that item's field directly.
  assign out_valid              = valid_r;
  assign out_stable             = stable_r;
  assign out_stable_temperature = latched_r;
  assign out_window_mean        = mean_r;
  assign out_window_full        = full_r;
  assign out_near_setpoint      = near_r;
  assign out_low_spread         = low_r;

`ifndef SYNTH
  a_stable_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && stable_r |-> full_r)
    else $error("stable reported on a window that is not full");

  a_tests_need_full: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (near_r || low_r) |-> full_r)
    else $error("window tests reported before the window filled");

  a_stable_has_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> cand_r)
    else $error("stable set without an active dwell candidate");

  a_dwell_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    dwell_r <= DWELL_MAX)
    else $error("dwell counter ran past its saturation point");
`endif

endmodule
`default_nettype wire

### tb/wtsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsd_checker: result checker for the temperature stability detector
// Follows every accepted item and register write, keeps its own copy of the
// reading window, sums and dwell timer, and compares each accepted result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wtsd_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [wtsd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wtsd_pkg::TEMP_W-1:0]              cfg_wdata,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic                                     in_command,
  input  logic signed [wtsd_pkg::TEMP_W-1:0]       in_temperature,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic                                     out_stable,
  input  logic signed [wtsd_pkg::TEMP_W-1:0]       out_stable_temperature,
  input  logic signed [wtsd_pkg::TEMP_W-1:0]       out_window_mean,
  input  logic                                     out_window_full,
  input  logic                                     out_near_setpoint,
  input  logic                                     out_low_spread,
  output int                                       fail_count,
  output int                                       pending_count,
  output int                                       checked_count,
  output int                                       stable_count
);

  import wtsd_pkg::*;

  localparam int WINDOW = WINDOW_DEF;

  typedef struct packed {
    logic                     stable;
    logic signed [TEMP_W-1:0] stable_temperature;
    logic signed [TEMP_W-1:0] window_mean;
    logic                     window_full;
    logic                     near_setpoint;
    logic                     low_spread;
  } detector_result_t;

  detector_result_t expected_results[$];

  // Predicted detector state.
  logic signed [TEMP_W-1:0] history [WINDOW];
  int                       slot;
  int                       readings_held;
  longint                   sum_readings;
  longint                   sum_squares;
  logic                     holding;
  int                       held_seconds;
  logic                     declared;
  logic signed [TEMP_W-1:0] declared_mean;

  // Register copies.
  logic signed [TEMP_W-1:0] setpoint_reg;
  logic [THR_W-1:0]         threshold_reg;
  logic [DWELL_W-1:0]       dwell_reg;

  function automatic longint floor_by_window(input longint s);
    if (s >= 0) return s / WINDOW;
    return -((-s + WINDOW - 1) / WINDOW);
  endfunction

  task automatic forget_history();
    for (int i = 0; i < WINDOW; i++) history[i] = '0;
    slot          = 0;
    readings_held = 0;
    sum_readings  = 0;
    sum_squares   = 0;
    holding       = 1'b0;
    held_seconds  = 0;
    declared      = 1'b0;
  endtask

  task automatic predict_result(input logic clear, input logic signed [TEMP_W-1:0] reading);
    detector_result_t res;
    longint           oldest;
    longint           offset;
    longint           spread;
    longint           thr;
    longint           mean;
    logic             full;
    logic             near;
    logic             low;
    mean = 0;
    full = 1'b0;
    near = 1'b0;
    low  = 1'b0;
    if (clear) begin
      forget_history();
    end else begin
      oldest        = longint'(history[slot]);
      sum_readings  = sum_readings + longint'(reading) - oldest;
      sum_squares   = sum_squares + longint'(reading) * longint'(reading) - oldest * oldest;
      history[slot] = reading;
      slot          = (slot + 1) % WINDOW;
      if (readings_held < WINDOW) readings_held++;
      mean = floor_by_window(sum_readings);
      full = (readings_held >= WINDOW);
      if (full) begin
        thr    = longint'(threshold_reg);
        offset = sum_readings - longint'(WINDOW) * longint'(setpoint_reg);
        if (offset < 0) offset = -offset;
        spread = longint'(WINDOW) * sum_squares - sum_readings * sum_readings;
        near   = (offset < longint'(WINDOW) * thr);
        low    = (spread < longint'(WINDOW) * longint'(WINDOW) * thr * thr);
        if (near && low) begin
          if (!holding) begin
            holding      = 1'b1;
            held_seconds = 0;
          end else if (held_seconds < int'(DWELL_MAX)) begin
            held_seconds++;
          end
          if (held_seconds >= int'(dwell_reg) && !declared) begin
            declared      = 1'b1;
            declared_mean = mean[TEMP_W-1:0];
          end
        end else begin
          holding      = 1'b0;
          held_seconds = 0;
          declared     = 1'b0;
        end
      end
    end
    res.stable             = declared;
    res.stable_temperature = declared_mean;
    res.window_mean        = mean[TEMP_W-1:0];
    res.window_full        = full;
    res.near_setpoint      = near;
    res.low_spread         = low;
    expected_results.push_back(res);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    detector_result_t want;
    if (!rst_n) begin
      forget_history();
      declared_mean = '0;
      setpoint_reg  = SETPOINT_RST;
      threshold_reg = THRESHOLD_RST;
      dwell_reg     = DWELL_RST;
      expected_results.delete();
      fail_count    = 0;
      checked_count = 0;
      stable_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETPOINT:  setpoint_reg  = cfg_wdata;
          CFG_THRESHOLD: threshold_reg = cfg_wdata[THR_W-1:0];
          CFG_DWELL:     dwell_reg     = cfg_wdata[DWELL_W-1:0];
          default: ;
        endcase
      end
      // The command bit is a clear request: the reading is ignored when set.
      if (in_valid && !in_stall) predict_result(in_command, in_temperature);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result: accepted with no item outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("stable", want.stable, out_stable);
          compare_field("stable_temperature", want.stable_temperature, out_stable_temperature);
          compare_field("window_mean", want.window_mean, out_window_mean);
          compare_field("window_full", want.window_full, out_window_full);
          compare_field("near_setpoint", want.near_setpoint, out_near_setpoint);
          compare_field("low_spread", want.low_spread, out_low_spread);
          checked_count++;
          if (out_stable) stable_count++;
        end
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the windowed temperature stability detector
// Drives directed and randomised reading sequences through several register
// settings, with random idling on both channels, and reports the verdict
// from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;

  import wtsd_pkg::*;

  localparam logic CMD_READING = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int TEMP_MIN        = -5000;
  localparam int TEMP_MAX        = 30000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int DRAIN_CYCLES    = 12;
  localparam int DRAIN_LIMIT     = 100000;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [TEMP_W-1:0]        cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_command;
  logic signed [TEMP_W-1:0] in_temperature;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_stable;
  logic signed [TEMP_W-1:0] out_stable_temperature;
  logic signed [TEMP_W-1:0] out_window_mean;
  logic                     out_window_full;
  logic                     out_near_setpoint;
  logic                     out_low_spread;

  int fail_count;
  int pending_count;
  int checked_count;
  int stable_count;

  logic quiet = 1'b0;
  int   items_sent;
  int   clears_sent;
  int   settings_used;
  int   cur_setpoint;
  int   cur_threshold;
  int   cur_dwell;

  windowed_temperature_stability_detector_top #(
    .WINDOW(WINDOW_DEF)
  ) uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_temperature         (in_temperature),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_stable             (out_stable),
    .out_stable_temperature (out_stable_temperature),
    .out_window_mean        (out_window_mean),
    .out_window_full        (out_window_full),
    .out_near_setpoint      (out_near_setpoint),
    .out_low_spread         (out_low_spread)
  );

  wtsd_checker checker_i (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_temperature         (in_temperature),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_stable             (out_stable),
    .out_stable_temperature (out_stable_temperature),
    .out_window_mean        (out_window_mean),
    .out_window_full        (out_window_full),
    .out_near_setpoint      (out_near_setpoint),
    .out_low_spread         (out_low_spread),
    .fail_count             (fail_count),
    .pending_count          (pending_count),
    .checked_count          (checked_count),
    .stable_count           (stable_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 15);
    end
  end

  initial begin
    #12_000_000;
    $display("windowed_temperature_stability_detector_top: mismatch");
    $finish;
  end

  function automatic int clamp_reading(input int v);
    if (v < TEMP_MIN) return TEMP_MIN;
    if (v > TEMP_MAX) return TEMP_MAX;
    return v;
  endfunction

  function automatic int around(input int centre, input int amp);
    return centre + int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  task automatic send_item(input logic cmd, input int reading);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_temperature <= reading[TEMP_W-1:0];
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  task automatic send_reading(input int reading);
    send_item(CMD_READING, clamp_reading(reading));
  endtask

  task automatic send_clear();
    // The reading travels with the clear but must be ignored.
    send_item(CMD_CLEAR, int'($urandom_range(0, 16'hFFFF)));
  endtask

  // Holds the sender off until every outstanding result has been returned.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Bits above a register's width are filled at random when garble is set;
  // the block must ignore them.
  task automatic program_registers(input int sp, input int th, input int dw, input bit garble);
    write_reg(CFG_SETPOINT, sp[TEMP_W-1:0]);
    write_reg(CFG_THRESHOLD, {garble ? 6'($urandom) : 6'd0, th[THR_W-1:0]});
    write_reg(CFG_DWELL, {garble ? 4'($urandom) : 4'd0, dw[DWELL_W-1:0]});
    cur_setpoint  = sp;
    cur_threshold = th;
    cur_dwell     = dw;
    settings_used++;
  endtask

  // One burst of items: mostly a settled run around the setpoint long enough
  // to fill the window and at times to run out the dwell time, otherwise
  // noise, a step away from the setpoint, or a clear.
  task automatic run_burst();
    int kind;
    int len;
    int base;
    int amp;
    int reach;
    kind  = $urandom_range(99);
    reach = cur_threshold + cur_threshold / 4;
    if (kind < 70) begin
      base = around(cur_setpoint, reach);
      amp  = $urandom_range(0, cur_threshold + 2);
      len  = WINDOW_DEF + $urandom_range(0, (cur_dwell > 40 ? 40 : cur_dwell) + 10);
      repeat (len) send_reading(around(base, amp));
    end else if (kind < 85) begin
      len = $urandom_range(1, 8);
      repeat (len) send_reading(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
    end else if (kind < 95) begin
      len = $urandom_range(1, 4);
      amp = cur_threshold + int'($urandom_range(50, 500));
      base = ($urandom_range(1) != 0) ? cur_setpoint + amp : cur_setpoint - amp;
      repeat (len) send_reading(around(base, 10));
    end else begin
      send_clear();
    end
  endtask

  initial begin
    int target;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_command     <= CMD_READING;
    in_temperature <= '0;
    items_sent    = 0;
    clears_sent   = 0;
    settings_used = 1;
    cur_setpoint  = int'(SETPOINT_RST);
    cur_threshold = int'(THRESHOLD_RST);
    cur_dwell     = int'(DWELL_RST);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill the window at the setpoint, run out the default dwell,
    // then break stability with both reading extremes and clear.
    send_clear();
    repeat (WINDOW_DEF + int'(DWELL_RST)) send_reading(int'(SETPOINT_RST));
    send_reading(TEMP_MIN);
    send_reading(TEMP_MAX);
    send_clear();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: program_registers(TEMP_MIN, 0, 0, 1'b0);
          2: program_registers(TEMP_MAX, 1000, int'(DWELL_MAX), 1'b1);
          3: program_registers(around(12500, 17500), $urandom_range(1, 100), 0, 1'b0);
          default: program_registers(around(12500, 17500), $urandom_range(0, 150),
                                     $urandom_range(0, 25), phase[0]);
        endcase
        if (phase == 4) write_reg(CFG_SPARE, 16'($urandom));
      end
      quiet <= (phase == 3);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) run_burst();
    end
    quiet <= 1'b0;

    // Dwell above the saturation point: the counter stops at its ceiling, so
    // stable must never be declared however long the conditions hold.
    wait_drained();
    program_registers(-1200, 50, 4095, 1'b0);
    send_clear();
    repeat (WINDOW_DEF + 60) send_reading(around(-1200, 10));

    in_valid <= 1'b0;
    target = 0;
    do begin
      @(posedge clk);
      target++;
    end while (pending_count != 0 && target < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, %0d of them clears, across %0d register settings.",
             items_sent, clears_sent, settings_used);
    $display("Compared %0d results, %0d of them with a declared stable temperature.",
             checked_count, stable_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("windowed_temperature_stability_detector_top: match");
    end else begin
      $display("windowed_temperature_stability_detector_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
src/wtsd_pkg.sv
src/wtsd_ring.sv
src/wtsd_datapath.sv
src/windowed_temperature_stability_detector_top.sv
tb/wtsd_checker.sv
tb/tb_top.sv
